>>> rtl/core/rope_pkg.sv
// ----------------------------------------------------------------------------
// rope_pkg: shared types and constant tables for the rotary position embedding
// Holds the transaction structs, the per-pair frequency table, the CORDIC
// arctangent table and the CORDIC gain. The tables are built at elaboration.
// ----------------------------------------------------------------------------
package rope_pkg;

    // Block configuration
    localparam int EMBED_DIM    = 64;
    localparam int THETA        = 10000;
    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_DEPTH  = 32;

    // Depth of the pipeline between input and result:
    // three front-end stages, one per CORDIC cell, three back-end stages
    localparam int LATENCY = CORDIC_STEPS + 6;

    // Derived widths
    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int SHIFT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int CW      = 34;   // CORDIC x, y, z datapath
    localparam int CS_W    = 18;   // rounded cos / sin, Q1.14 plus headroom
    localparam int PROD_W  = 34;   // element times cos / sin
    localparam int SUM_W   = 36;   // difference or sum of two products

    localparam logic [63:0] INV_TWO_PI_Q32 = 64'd683565276;
    localparam logic [63:0] FRAC30         = 64'd1 << 30;

    localparam logic signed [CW-1:0] QUARTER_TURN = CW'(64'd1 << 30);
    localparam logic signed [CW-1:0] HALF_TURN    = CW'(64'd1 << 31);
    localparam logic signed [CW-1:0] CS_ROUND     = CW'(64'd1 << 15);
    localparam logic signed [SUM_W-1:0] PROD_ROUND = SUM_W'(64'd1 << 13);
    localparam logic signed [SUM_W-1:0] SAT_MAX    = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAT_MIN    = -SUM_W'(32768);

    // Input and result transactions
    typedef struct packed {
        logic signed [15:0] x_even;
        logic signed [15:0] x_odd;
        logic [15:0]        position;
        logic [4:0]         pair_index;
    } rope_in_t;

    typedef struct packed {
        logic signed [15:0] y_even;
        logic signed [15:0] y_odd;
        logic               saturated;
    } rope_out_t;

    // Data handed from cell to cell along the CORDIC chain
    typedef struct packed {
        logic               valid;
        logic               flip;
        logic signed [15:0] x_even;
        logic signed [15:0] x_odd;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } rope_cell_t;

    typedef logic [31:0] freq_table_t [TABLE_DEPTH];
    typedef logic signed [CW-1:0] atan_table_t [CORDIC_STEPS];

    // Integer square root, bit by bit
    function automatic logic [63:0] isqrt64(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] rem;
        r   = 64'd0;
        b   = 64'd1 << 62;
        rem = v;
        for (int i = 0; i < 32; i++)
        begin
            if (rem >= r + b)
            begin
                rem = rem - (r + b);
                r   = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Restoring long division, used only while building tables
    function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        rem = 65'd0;
        q   = 64'd0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], n[i]};
            if (rem >= {1'b0, d})
            begin
                rem  = rem - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Frequency per pair in turns per position, Q0.32
    function automatic freq_table_t build_freq_table();
        freq_table_t tbl;
        logic [63:0] roots [31];
        logic [63:0] t;
        logic [63:0] m;
        logic [63:0] lg;
        logic [63:0] e;
        logic [63:0] ei;
        logic [63:0] ef;
        logic [63:0] mant;
        logic [63:0] f;
        int n;
        t = 64'(THETA);
        n = 0;
        for (int j = 1; j < 63; j++)
        begin
            if ((t >> j) != 64'd0)
                n = j;
        end
        m  = (t << 30) >> n;
        lg = 64'(n) << 30;
        for (int j = 0; j < 30; j++)
        begin
            m = (m * m) >> 30;
            if (m >= (FRAC30 << 1))
            begin
                m  = m >> 1;
                lg = lg | (64'd1 << (29 - j));
            end
        end
        roots[0] = 64'd0;
        roots[1] = isqrt64(64'd1 << 63);
        for (int j = 2; j <= 30; j++)
            roots[j] = isqrt64(roots[j-1] << 32);
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            e    = (lg * 64'(2 * k)) / 64'(EMBED_DIM);
            ei   = e >> 30;
            ef   = e & (FRAC30 - 64'd1);
            mant = 64'd1 << 32;
            for (int j = 1; j <= 30; j++)
            begin
                if (((ef >> (30 - j)) & 64'd1) != 64'd0)
                    mant = (mant * roots[j]) >> 32;
            end
            f      = (mant * INV_TWO_PI_Q32) >> 32;
            tbl[k] = (ei >= 64'd32) ? 32'd0 : 32'(f >> ei);
        end
        return tbl;
    endfunction

    // Arctangent of 2^-i in Q0.32 turns
    function automatic atan_table_t build_atan_table();
        atan_table_t tbl;
        logic signed [63:0] sum;
        logic signed [63:0] term;
        logic [63:0] us;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (i == 0)
            begin
                tbl[i] = CW'(64'd1 << 29);
            end
            else
            begin
                sum = 64'sd0;
                for (int q = 0; q < 31; q++)
                begin
                    if (i * (2 * q + 1) <= 60)
                    begin
                        term = $signed(udiv64(64'd1 << (60 - i * (2 * q + 1)),
                                              64'(2 * q + 1)));
                        sum  = (q % 2 == 1) ? sum - term : sum + term;
                    end
                end
                us     = 64'(sum >>> 26);
                tbl[i] = CW'((us * INV_TWO_PI_Q32) >> 34);
            end
        end
        return tbl;
    endfunction

    // Inverse CORDIC gain, Q.30
    function automatic logic signed [CW-1:0] build_gain();
        logic [63:0] kg;
        logic [63:0] add;
        logic [63:0] s;
        kg = 64'd1 << 32;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            add = (2 * i <= 30) ? (64'd1 << (30 - 2 * i)) : 64'd0;
            s   = isqrt64((FRAC30 + add) << 30);
            kg  = udiv64(kg << 30, s);
        end
        return CW'(kg >> 2);
    endfunction

    localparam freq_table_t FREQ_TABLE = build_freq_table();
    localparam atan_table_t ATAN_TABLE = build_atan_table();
    localparam logic signed [CW-1:0] CORDIC_GAIN = build_gain();

endpackage

>>> rtl/core/rotary_position_embedding.sv
// ----------------------------------------------------------------------------
// rotary_position_embedding: rotates one query/key element pair per cycle
// Top level: angle front end, a chain of CORDIC cells and the rotate stage.
// ----------------------------------------------------------------------------
// Usage:
//   Drive pair (x_even, x_odd, position, pair_index) and raise start; the
//   transaction is taken at a clock edge where start is high and busy low.
//   busy is high only while reset is held and for the first edge after it,
//   then stays low: a new pair can be taken every cycle.
//   Each result appears on rotated for exactly one cycle with done high and
//   is registered through three front-end stages (table lookup, angle
//   product, quadrant fold), one register per CORDIC cell, then cos/sin
//   rounding, the products and the round-and-saturate stage. Results leave
//   in the order pairs came in.
//   Throughput is one pair per cycle, set by the fully pipelined cell chain.
//   The receiver cannot stall; it must take done/rotated as they come.
//   Reset clears all valid flags, so no stale result is ever presented;
//   the frequency and arctangent tables are constants and need no fill.
// ----------------------------------------------------------------------------
module rotary_position_embedding
    import rope_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  rope_in_t  pair,
    output logic      done,
    output rope_out_t rotated
);

    logic       busy_reg;
    logic       accept;
    rope_cell_t chain [CORDIC_STEPS+1];

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    // Held off only through reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b1;
        else
            busy_reg <= 1'b0;
    end

    rope_angle u_angle (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .pair   (pair),
        .seed   (chain[0])
    );

    // CORDIC cell chain
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        rope_cordic_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (SHIFT_W'(i)),
            .atan  (ATAN_TABLE[i]),
            .d_in  (chain[i]),
            .d_out (chain[i+1])
        );
    end

    rope_rotate u_rotate (
        .clk     (clk),
        .rst_n   (rst_n),
        .d_in    (chain[CORDIC_STEPS]),
        .done    (done),
        .rotated (rotated)
    );

    // Every result traces back to an earlier taken transaction
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without matching input transaction");

    // Every taken transaction yields a result
    a_source_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("input transaction produced no result");

    // A flagged result carries a clipped value
    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rotated.saturated) |->
            (rotated.y_even == 16'sh7fff || rotated.y_even == 16'sh8000 ||
             rotated.y_odd == 16'sh7fff || rotated.y_odd == 16'sh8000))
        else $error("saturation flag set without clipped result");

    // Once released from reset the block never holds off input
    a_busy_stays_low: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !busy)
        else $error("busy raised after reset");

endmodule

>>> rtl/core/rope_angle.sv
// ----------------------------------------------------------------------------
// rope_angle: front end of the rotary embedding pipeline
// Looks up the pair frequency, forms position times frequency in turns and
// folds the angle into +-1/4 turn, seeding the first CORDIC cell.
// ----------------------------------------------------------------------------
module rope_angle
    import rope_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  rope_in_t   pair,
    output rope_cell_t seed
);

    // Stage 1: frequency lookup
    logic        s1_valid_reg;
    rope_in_t    s1_item_reg;
    logic [31:0] s1_freq_reg;

    // Stage 2: angle product
    logic               s2_valid_reg;
    logic signed [15:0] s2_xe_reg;
    logic signed [15:0] s2_xo_reg;
    logic [31:0]        s2_angle_reg;
    logic [31:0]        s2_angle_next;
    logic [47:0]        angle_full;

    // Stage 3: quadrant fold
    logic                 s3_valid_reg;
    logic                 s3_flip_reg;
    logic                 s3_flip_next;
    logic signed [15:0]   s3_xe_reg;
    logic signed [15:0]   s3_xo_reg;
    logic signed [CW-1:0] s3_z_reg;
    logic signed [CW-1:0] s3_z_next;
    logic signed [CW-1:0] z_wide;

    assign angle_full    = 48'(s1_item_reg.position) * 48'(s1_freq_reg);
    assign s2_angle_next = angle_full[31:0];

    // Signed turns, moved by half a turn when beyond a quarter turn
    always_comb
    begin
        z_wide       = CW'($signed(s2_angle_reg));
        s3_z_next    = z_wide;
        s3_flip_next = 1'b0;
        if (z_wide > QUARTER_TURN)
        begin
            s3_z_next    = z_wide - HALF_TURN;
            s3_flip_next = 1'b1;
        end
        else if (z_wide < -QUARTER_TURN)
        begin
            s3_z_next    = z_wide + HALF_TURN;
            s3_flip_next = 1'b1;
        end
    end

    // Valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Payload pipeline
    always_ff @(posedge clk)
    begin
        s1_item_reg  <= pair;
        s1_freq_reg  <= FREQ_TABLE[pair.pair_index[IDX_W-1:0]];
        s2_xe_reg    <= s1_item_reg.x_even;
        s2_xo_reg    <= s1_item_reg.x_odd;
        s2_angle_reg <= s2_angle_next;
        s3_xe_reg    <= s2_xe_reg;
        s3_xo_reg    <= s2_xo_reg;
        s3_z_reg     <= s3_z_next;
        s3_flip_reg  <= s3_flip_next;
    end

    assign seed.valid  = s3_valid_reg;
    assign seed.flip   = s3_flip_reg;
    assign seed.x_even = s3_xe_reg;
    assign seed.x_odd  = s3_xo_reg;
    assign seed.x      = CORDIC_GAIN;
    assign seed.y      = '0;
    assign seed.z      = s3_z_reg;

endmodule

>>> rtl/core/rope_cordic_cell.sv
// ----------------------------------------------------------------------------
// rope_cordic_cell: one CORDIC rotation step
// Rotates (x, y) toward z = 0 by the arctangent of 2^-shift and hands the
// result to the next cell every cycle.
// ----------------------------------------------------------------------------
module rope_cordic_cell
    import rope_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [SHIFT_W-1:0]   shift,
    input  logic signed [CW-1:0] atan,
    input  rope_cell_t           d_in,
    output rope_cell_t           d_out
);

    logic       valid_reg;
    rope_cell_t data_reg;
    rope_cell_t data_next;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    assign dx = d_in.y >>> shift;
    assign dy = d_in.x >>> shift;

    // Rotation direction follows the sign of the residual angle
    always_comb
    begin
        data_next = d_in;
        if (d_in.z >= 0)
        begin
            data_next.x = d_in.x - dx;
            data_next.y = d_in.y + dy;
            data_next.z = d_in.z - atan;
        end
        else
        begin
            data_next.x = d_in.x + dx;
            data_next.y = d_in.y - dy;
            data_next.z = d_in.z + atan;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= d_in.valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        d_out       = data_reg;
        d_out.valid = valid_reg;
    end

endmodule

>>> rtl/core/rope_rotate.sv
// ----------------------------------------------------------------------------
// rope_rotate: back end of the rotary embedding pipeline
// Rounds the CORDIC vector to Q1.14 cos and sin, rotates the element pair
// and saturates both results to 16 bits.
// ----------------------------------------------------------------------------
module rope_rotate
    import rope_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  rope_cell_t d_in,
    output logic       done,
    output rope_out_t  rotated
);

    // Stage 1: cos and sin
    logic                   r1_valid_reg;
    logic signed [15:0]     r1_xe_reg;
    logic signed [15:0]     r1_xo_reg;
    logic signed [CS_W-1:0] r1_cos_reg;
    logic signed [CS_W-1:0] r1_sin_reg;
    logic signed [CS_W-1:0] r1_cos_next;
    logic signed [CS_W-1:0] r1_sin_next;
    logic signed [CW-1:0]   cos_full;
    logic signed [CW-1:0]   sin_full;

    // Stage 2: products
    logic                     r2_valid_reg;
    logic signed [PROD_W-1:0] r2_ec_reg;
    logic signed [PROD_W-1:0] r2_es_reg;
    logic signed [PROD_W-1:0] r2_oc_reg;
    logic signed [PROD_W-1:0] r2_os_reg;
    logic signed [PROD_W-1:0] r2_ec_next;
    logic signed [PROD_W-1:0] r2_es_next;
    logic signed [PROD_W-1:0] r2_oc_next;
    logic signed [PROD_W-1:0] r2_os_next;

    // Stage 3: round and saturate
    logic                    done_reg;
    rope_out_t               result_reg;
    rope_out_t               result_next;
    logic signed [SUM_W-1:0] ye_sum;
    logic signed [SUM_W-1:0] yo_sum;
    logic signed [SUM_W-1:0] ye_rnd;
    logic signed [SUM_W-1:0] yo_rnd;
    logic                    ye_clip;
    logic                    yo_clip;

    // Round to Q1.14, undo the half-turn fold
    assign cos_full = (d_in.x + CS_ROUND) >>> 16;
    assign sin_full = (d_in.y + CS_ROUND) >>> 16;

    always_comb
    begin
        r1_cos_next = cos_full[CS_W-1:0];
        r1_sin_next = sin_full[CS_W-1:0];
        if (d_in.flip)
        begin
            r1_cos_next = -cos_full[CS_W-1:0];
            r1_sin_next = -sin_full[CS_W-1:0];
        end
    end

    assign r2_ec_next = r1_xe_reg * r1_cos_reg;
    assign r2_es_next = r1_xe_reg * r1_sin_reg;
    assign r2_oc_next = r1_xo_reg * r1_cos_reg;
    assign r2_os_next = r1_xo_reg * r1_sin_reg;

    assign ye_sum = SUM_W'(r2_ec_reg) - SUM_W'(r2_os_reg);
    assign yo_sum = SUM_W'(r2_es_reg) + SUM_W'(r2_oc_reg);
    assign ye_rnd = (ye_sum + PROD_ROUND) >>> 14;
    assign yo_rnd = (yo_sum + PROD_ROUND) >>> 14;

    // Clip to 16 bits and flag
    always_comb
    begin
        ye_clip = (ye_rnd > SAT_MAX) || (ye_rnd < SAT_MIN);
        yo_clip = (yo_rnd > SAT_MAX) || (yo_rnd < SAT_MIN);
        result_next.y_even = ye_rnd[15:0];
        result_next.y_odd  = yo_rnd[15:0];
        if (ye_rnd > SAT_MAX)
            result_next.y_even = SAT_MAX[15:0];
        else if (ye_rnd < SAT_MIN)
            result_next.y_even = SAT_MIN[15:0];
        if (yo_rnd > SAT_MAX)
            result_next.y_odd = SAT_MAX[15:0];
        else if (yo_rnd < SAT_MIN)
            result_next.y_odd = SAT_MIN[15:0];
        result_next.saturated = ye_clip || yo_clip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_valid_reg <= 1'b0;
            r2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            r1_valid_reg <= d_in.valid;
            r2_valid_reg <= r1_valid_reg;
            done_reg     <= r2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        r1_xe_reg  <= d_in.x_even;
        r1_xo_reg  <= d_in.x_odd;
        r1_cos_reg <= r1_cos_next;
        r1_sin_reg <= r1_sin_next;
        r2_ec_reg  <= r2_ec_next;
        r2_es_reg  <= r2_es_next;
        r2_oc_reg  <= r2_oc_next;
        r2_os_reg  <= r2_os_next;
        result_reg <= result_next;
    end

    assign done    = done_reg;
    assign rotated = result_reg;

endmodule
